@@ hdl/char_lcd_diff_update_engine_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the character LCD diff update engine
// Shared forms for concurrent checks: implication in the same cycle and in
// the next cycle, both disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_DIFF_UPDATE_ENGINE_CORE_ASSERT_SVH
`define CHAR_LCD_DIFF_UPDATE_ENGINE_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CLDU_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cldu assertion failed");

// antecedent implies consequent in the following cycle
`define CLDU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cldu assertion failed");

`endif

@@ hdl/cldu_pkg.sv @@
// ----------------------------------------------------------------------------
// cldu_pkg
// Types, constants and small lookup functions shared by the character LCD
// diff update engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cldu_pkg;

  localparam int MAX_ROWS     = 4;
  localparam int MAX_LINE     = 40;
  localparam int ROW_W        = 2;
  localparam int COL_W        = 6;
  localparam int ROW_COUNT_W  = 3;
  localparam int SHADOW_DEPTH = MAX_ROWS * MAX_LINE;
  localparam int SHADOW_AW    = $clog2(SHADOW_DEPTH);
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 6;

  // item kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_EOL   = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_LENGTH = 1'b1;

  localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET   = 3'd2;
  localparam logic [COL_W-1:0]       LINE_LENGTH_RESET = 6'd40;

  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       is_command;
    logic       last;
  } out_item_t;

  // display RAM base address of each row
  function automatic logic [7:0] row_base(input logic [ROW_W-1:0] row);
    logic [7:0] base;
    case (row)
      2'd0:    base = 8'h00;
      2'd1:    base = 8'h40;
      2'd2:    base = 8'h14;
      2'd3:    base = 8'h54;
      default: base = 8'h00;
    endcase
    return base;
  endfunction

  // characters the display font has, everything else becomes 0
  function automatic logic [7:0] map_char(input logic [7:0] c);
    logic [7:0] m;
    if (c >= 8'h20 && c <= 8'h3F) begin
      m = c;
    end else if (c >= 8'h41 && c <= 8'h5B) begin
      m = c;
    end else if (c >= 8'h5D && c <= 8'h7D) begin
      m = c;
    end else begin
      m = 8'h00;
    end
    return m;
  endfunction

endpackage

@@ hdl/cldu_shadow_ram.sv @@
// ----------------------------------------------------------------------------
// cldu_shadow_ram
// Shadow copy of the screen characters: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cldu_shadow_ram (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [cldu_pkg::SHADOW_AW-1:0] wr_addr,
  input  logic [7:0]                     wr_data,
  input  logic                           rd_en,
  input  logic [cldu_pkg::SHADOW_AW-1:0] rd_addr,
  output logic [7:0]                     rd_data
);

  logic [7:0] mem [cldu_pkg::SHADOW_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/char_lcd_diff_update_engine_core.sv @@
// ----------------------------------------------------------------------------
// char_lcd_diff_update_engine_core
// Turns a text item stream into character LCD command and data bytes,
// skipping characters that already stand on the display.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------
//   in       | sink      | in_valid / in_stall   | in_item_t  (kind, char)
//   out      | source    | out_valid / out_stall | out_item_t (byte, cmd, last)
//   cfg      | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// steps: start of text sends a set-address byte, clear a clear command, a
//   dropped character none; a character reads the shadow RAM, is skipped on a
//   match, else sends its address and itself; end of line sends its address,
//   spaces to line length, next row's address; one byte a cycle unless stalled.
// reset: synchronous; row 0, column 0, all row lengths 0, registers at
//   row_count 2 and line_length 40. shadow RAM is not cleared.
// a stalled output holds the sequencer; in_stall is high while busy.
`timescale 1ns / 1ps

module char_lcd_diff_update_engine_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  cldu_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output cldu_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cldu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cldu_pkg::CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_ADDR = 5'b00100,
    S_PAD  = 5'b01000,
    S_TAIL = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [cldu_pkg::ROW_COUNT_W-1:0] row_count;
  logic [cldu_pkg::COL_W-1:0]       line_length;
  logic [cldu_pkg::ROW_W-1:0]       cur_row;
  logic [cldu_pkg::COL_W-1:0]       cur_col;
  logic [cldu_pkg::COL_W-1:0]       row_len [cldu_pkg::MAX_ROWS];

  logic [1:0]                       op_kind;
  logic [7:0]                       op_code;
  logic [cldu_pkg::ROW_W-1:0]       op_row;
  logic [cldu_pkg::COL_W-1:0]       op_col;
  logic [cldu_pkg::SHADOW_AW-1:0]   op_addr;
  logic [cldu_pkg::COL_W-1:0]       pad_left;

  logic [cldu_pkg::COL_W-1:0]       eff_len;
  logic                             col_in_line;
  logic [cldu_pkg::COL_W-1:0]       used;
  logic [cldu_pkg::ROW_COUNT_W-1:0] row_inc;
  logic [cldu_pkg::ROW_W-1:0]       next_row;
  logic                             accept;
  logic                             emit;
  logic                             load;
  logic                             same;
  logic [cldu_pkg::SHADOW_AW-1:0]   rd_addr;
  logic [7:0]                       rd_data;
  logic [cldu_pkg::ROW_W-1:0]       a_row;
  logic [cldu_pkg::COL_W-1:0]       a_col;
  logic [7:0]                       addr_sum;
  cldu_pkg::out_item_t              item_next;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign eff_len = (line_length > cldu_pkg::COL_W'(cldu_pkg::MAX_LINE))
                   ? cldu_pkg::COL_W'(cldu_pkg::MAX_LINE) : line_length;
  assign col_in_line = (cur_col < eff_len);
  assign used        = col_in_line ? cur_col : eff_len;

  assign row_inc  = {1'b0, cur_row} + 3'd1;
  assign next_row = (row_inc >= row_count ||
                     row_inc >= cldu_pkg::ROW_COUNT_W'(cldu_pkg::MAX_ROWS))
                    ? '0 : row_inc[cldu_pkg::ROW_W-1:0];

  assign rd_addr = cldu_pkg::SHADOW_AW'(cur_row) * cldu_pkg::SHADOW_AW'(cldu_pkg::MAX_LINE)
                   + cldu_pkg::SHADOW_AW'(cur_col);

  cldu_shadow_ram u_shadow (
    .clk     (clk),
    .wr_en   (state == S_READ),
    .wr_addr (op_addr),
    .wr_data (op_code),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign same = (op_col < row_len[op_row]) && (rd_data == op_code);

  // shared address adder: item address, or column 0 of the new row at the tail
  assign a_row    = (state == S_TAIL) ? cur_row : op_row;
  assign a_col    = (state == S_TAIL) ? '0 : op_col;
  assign addr_sum = (cldu_pkg::CMD_SET_ADDR | cldu_pkg::row_base(a_row)) + 8'(a_col);

  assign emit = (state == S_ADDR) || (state == S_PAD) || (state == S_TAIL);
  assign load = emit && (!out_valid || !out_stall);

  always_comb begin
    item_next = '0;
    case (state)
      S_ADDR: begin
        item_next.lcd_byte   = addr_sum;
        item_next.is_command = 1'b1;
        item_next.last       = (op_kind == cldu_pkg::KIND_START);
      end
      S_PAD: begin
        item_next.lcd_byte   = cldu_pkg::CHAR_SPACE;
        item_next.is_command = 1'b0;
        item_next.last       = 1'b0;
      end
      S_TAIL: begin
        item_next.last = 1'b1;
        case (op_kind)
          cldu_pkg::KIND_CHAR: begin
            item_next.lcd_byte   = cldu_pkg::map_char(op_code);
            item_next.is_command = 1'b0;
          end
          cldu_pkg::KIND_EOL: begin
            item_next.lcd_byte   = addr_sum;
            item_next.is_command = 1'b1;
          end
          default: begin
            item_next.lcd_byte   = cldu_pkg::CMD_CLEAR;
            item_next.is_command = 1'b1;
          end
        endcase
      end
      default: begin
        item_next = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_data.kind)
            cldu_pkg::KIND_CHAR:  state_next = col_in_line ? S_READ : S_IDLE;
            cldu_pkg::KIND_CLEAR: state_next = S_TAIL;
            default:              state_next = S_ADDR;
          endcase
        end
      end
      S_READ: begin
        state_next = same ? S_IDLE : S_ADDR;
      end
      S_ADDR: begin
        if (load) begin
          case (op_kind)
            cldu_pkg::KIND_START: state_next = S_IDLE;
            cldu_pkg::KIND_EOL:   state_next = (pad_left != '0) ? S_PAD : S_TAIL;
            default:              state_next = S_TAIL;
          endcase
        end
      end
      S_PAD: begin
        if (load && pad_left == cldu_pkg::COL_W'(1)) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      row_count   <= cldu_pkg::ROW_COUNT_RESET;
      line_length <= cldu_pkg::LINE_LENGTH_RESET;
      cur_row     <= '0;
      cur_col     <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < cldu_pkg::MAX_ROWS; i++) begin
        row_len[i] <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cldu_pkg::CFG_ROW_COUNT:   row_count   <= cfg_data[cldu_pkg::ROW_COUNT_W-1:0];
          cldu_pkg::CFG_LINE_LENGTH: line_length <= cfg_data;
          default: ;
        endcase
      end

      if (accept) begin
        case (in_data.kind)
          cldu_pkg::KIND_START: begin
            cur_row <= '0;
            cur_col <= '0;
          end
          cldu_pkg::KIND_CHAR: begin
            // column saturates at its top code
            if (cur_col != '1) begin
              cur_col <= cur_col + 1'b1;
            end
          end
          cldu_pkg::KIND_EOL: begin
            row_len[cur_row] <= used;
            cur_row          <= next_row;
            cur_col          <= '0;
          end
          default: begin
            for (int i = 0; i < cldu_pkg::MAX_ROWS; i++) begin
              row_len[i] <= '0;
            end
          end
        endcase
      end

      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // transaction payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind <= in_data.kind;
      op_code <= in_data.char_code;
      op_addr <= rd_addr;
      case (in_data.kind)
        cldu_pkg::KIND_START: begin
          op_row <= '0;
          op_col <= '0;
        end
        cldu_pkg::KIND_EOL: begin
          op_row <= cur_row;
          op_col <= used;
        end
        default: begin
          op_row <= cur_row;
          op_col <= cur_col;
        end
      endcase
      pad_left <= eff_len - used;
    end else if (state == S_PAD && load) begin
      pad_left <= pad_left - 1'b1;
    end

    if (load) begin
      out_data <= item_next;
    end
  end

endmodule

@@ hdl/cldu_checker.sv @@
// ----------------------------------------------------------------------------
// cldu_checker
// Port-level checks on the character LCD diff update engine, bound to the
// top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "char_lcd_diff_update_engine_core_assert.svh"

module cldu_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input cldu_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input cldu_pkg::out_item_t out_data
);

  // a stalled result transaction holds
  `CLDU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
                    out_valid && $stable(out_data))

  // every item other than a character produces output, so the block goes busy
  `CLDU_ASSERT_NEXT(a_busy_after_item, clk, rst,
                    in_valid && !in_stall && in_data.kind != cldu_pkg::KIND_CHAR,
                    in_stall)

  // commands are set-address or a clear, and a clear ends its item
  `CLDU_ASSERT_SAME(a_cmd_form, clk, rst, out_valid && out_data.is_command,
                    out_data.lcd_byte[7] ||
                    (out_data.lcd_byte == cldu_pkg::CMD_CLEAR && out_data.last))

  // mapped data never reaches the upper half of the character set
  `CLDU_ASSERT_SAME(a_data_range, clk, rst, out_valid && !out_data.is_command,
                    !out_data.lcd_byte[7])

endmodule

bind char_lcd_diff_update_engine_core cldu_checker u_cldu_checker (.*);
